>>> rtl/multicast_group_table_macros.svh
// ----------------------------------------------------------------------------
// Multicast group table assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef MULTICAST_GROUP_TABLE_MACROS_SVH
`define MULTICAST_GROUP_TABLE_MACROS_SVH

// same-cycle implication
`define MCG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg
// Sizes, codes and types of the multicast group table.
// ----------------------------------------------------------------------------
package mcg_pkg;

    localparam int HASH_BUCKETS     = 256;
    localparam int OVERFLOW_ENTRIES = 256;
    localparam int SLOTS_PER_ENTRY  = 8;
    localparam int TOTAL_ENTRIES    = HASH_BUCKETS + OVERFLOW_ENTRIES;

    localparam int ENT_W     = $clog2(TOTAL_ENTRIES);
    localparam int OVF_W     = $clog2(OVERFLOW_ENTRIES);
    localparam int SLOT_W    = $clog2(SLOTS_PER_ENTRY);
    localparam int SCAN_W    = $clog2(SLOTS_PER_ENTRY + 1);
    localparam int STEP_W    = $clog2(TOTAL_ENTRIES + 1);
    localparam int ID_W      = 64;
    localparam int MEMBER_W  = 24;
    localparam int SLOT_BITS = MEMBER_W + 1;
    localparam int BUCKET_W  = 8;

    typedef logic [SLOT_BITS-1:0]                      slot_t;   // [24] valid, [23:0] member
    typedef logic [SLOTS_PER_ENTRY-1:0][SLOT_BITS-1:0] slot_row_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_FOUND   = 3'd1,
        ST_NO_MEMBER   = 3'd2,
        ST_FULL        = 3'd3,
        ST_NO_OVERFLOW = 3'd4,
        ST_BAD_CHAIN   = 3'd5
    } status_t;

    typedef enum logic {
        OP_ATTACH = 1'b0,
        OP_DETACH = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_ENT,
        S_CHK_ENT,
        S_FREE_SCAN,
        S_RD_ROW,
        S_SCAN,
        S_COMMIT,
        S_LINK,
        S_FIN
    } state_t;

    typedef struct packed {
        logic             rd_en;
        logic [ENT_W-1:0] rd_addr;
        logic [ENT_W-1:0] wr_addr;
        logic             id_we;
        logic [ID_W-1:0]  id_hi;
        logic [ID_W-1:0]  id_lo;
        logic             row_we;
        slot_row_t        row;
        logic             link_we;
        logic [ENT_W-1:0] link_addr;
        logic [ENT_W-1:0] link_data;
    } mem_req_t;

    typedef struct packed {
        logic [ID_W-1:0]  id_hi;
        logic [ID_W-1:0]  id_lo;
        logic [ENT_W-1:0] link;
        slot_row_t        row;
    } mem_rsp_t;

    typedef struct packed {
        status_t          status;
        logic [ENT_W-1:0] entry;
    } result_t;

endpackage

>>> rtl/multicast_group_table.sv
// ----------------------------------------------------------------------------
// multicast_group_table
// Multicast group membership table: hashed head entries chained to overflow
// entries, each entry holding a row of member slots.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel s_*: one beat per attach or detach. s_tuser carries the
//   operation (0 attach, 1 detach); s_tdata carries the group id halves, the
//   precomputed hash bucket and the 24-bit queue pair number.
//   Result channel m_*: one beat per request with status and the entry that
//   holds the group afterwards.
//   Sequencing: one request at a time. A request walks the chain from the
//   head entry of its bucket; an attach of a new group then searches the
//   free map for the lowest free overflow entry (up to 256 looked at). The
//   target row is read and its slots scanned, the commit writes it, and a
//   new overflow entry is then linked to the chain tail; a failing request
//   skips the commit. The next request can be taken in the cycle in which
//   the result is first offered on m_*. The chain walk and slot scan reuse
//   one id compare and one slot compare against the entry memories.
//   Reset: a clearing pass over all 512 entries zeroes ids, links and slot rows;
//   s_tready stays low until it is done. The overflow free map resets at once.
//   Stall: a finished result is held in the output register; the sequencer
//   waits in its final state until that register can take it, and takes no
//   new request meanwhile.
// ----------------------------------------------------------------------------
module multicast_group_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // [63:0] group_id_high, [127:64] group_id_low,
                                    // [135:128] bucket, [159:136] member_number
    input  logic [0:0]   s_tuser,   // [0] operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata    // [2:0] status, [11:3] entry_index, [15:12] zero
);

    mcg_pkg::mem_req_t mem_req;
    mcg_pkg::mem_rsp_t mem_rsp;
    mcg_pkg::result_t  res;
    logic              res_valid;
    logic              out_free;

    logic              m_tvalid_reg, m_tvalid_next;
    mcg_pkg::result_t  m_res_reg, m_res_next;

    // output register can take a result when empty or being drained
    assign out_free = !m_tvalid_reg || m_tready;

    mcg_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (mcg_pkg::op_t'(s_tuser[0])),
        .in_id_hi  (s_tdata[63:0]),
        .in_id_lo  (s_tdata[127:64]),
        .in_bucket (s_tdata[135:128]),
        .in_member (s_tdata[159:136]),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rsp   (mem_rsp)
    );

    mcg_mem u_mem (
        .aclk (aclk),
        .req  (mem_req),
        .rsp  (mem_rsp)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid) begin
            m_tvalid_next = 1'b1;
            m_res_next    = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_res_reg.entry, m_res_reg.status};

endmodule

>>> rtl/mcg_mem.sv
// ----------------------------------------------------------------------------
// mcg_mem
// Entry storage: group ids, next links and member slot rows, one read port
// with registered data and one write port per array.
// ----------------------------------------------------------------------------
module mcg_mem (
    input  logic              aclk,
    input  mcg_pkg::mem_req_t req,
    output mcg_pkg::mem_rsp_t rsp
);

    logic [mcg_pkg::ID_W-1:0]  id_hi_mem [mcg_pkg::TOTAL_ENTRIES];
    logic [mcg_pkg::ID_W-1:0]  id_lo_mem [mcg_pkg::TOTAL_ENTRIES];
    logic [mcg_pkg::ENT_W-1:0] link_mem  [mcg_pkg::TOTAL_ENTRIES];
    mcg_pkg::slot_row_t        row_mem   [mcg_pkg::TOTAL_ENTRIES];

    always_ff @(posedge aclk) begin
        if (req.id_we) begin
            id_hi_mem[req.wr_addr] <= req.id_hi;
            id_lo_mem[req.wr_addr] <= req.id_lo;
        end
        if (req.row_we) begin
            row_mem[req.wr_addr] <= req.row;
        end
        if (req.link_we) begin
            link_mem[req.link_addr] <= req.link_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rsp.id_hi <= id_hi_mem[req.rd_addr];
            rsp.id_lo <= id_lo_mem[req.rd_addr];
            rsp.link  <= link_mem[req.rd_addr];
            rsp.row   <= row_mem[req.rd_addr];
        end
    end

endmodule

>>> rtl/mcg_seq.sv
// ----------------------------------------------------------------------------
// mcg_seq
// Sequencer: clearing pass, chain walk, free overflow search, slot scan with
// one shared slot compare, and commit and tail link writes.
// ----------------------------------------------------------------------------
`include "multicast_group_table_macros.svh"

module mcg_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  mcg_pkg::op_t                  in_op,
    input  logic [mcg_pkg::ID_W-1:0]      in_id_hi,
    input  logic [mcg_pkg::ID_W-1:0]      in_id_lo,
    input  logic [mcg_pkg::BUCKET_W-1:0]  in_bucket,
    input  logic [mcg_pkg::MEMBER_W-1:0]  in_member,
    input  logic                          out_free,
    output logic                          res_valid,
    output mcg_pkg::result_t              res,
    output mcg_pkg::mem_req_t             mem_req,
    input  mcg_pkg::mem_rsp_t             mem_rsp
);

    localparam int ENT_W = mcg_pkg::ENT_W;
    localparam int SLOTS = mcg_pkg::SLOTS_PER_ENTRY;

    mcg_pkg::state_t state_reg, state_next;
    mcg_pkg::op_t    op_reg, op_next;
    logic [mcg_pkg::ID_W-1:0]     hi_reg, hi_next, lo_reg, lo_next;
    logic [mcg_pkg::MEMBER_W-1:0] member_reg, member_next;
    logic [ENT_W-1:0] cur_reg, cur_next, head_reg, head_next;
    logic [ENT_W-1:0] target_reg, target_next, tail_reg, tail_next;
    logic [ENT_W-1:0] clr_reg, clr_next;
    logic [mcg_pkg::STEP_W-1:0] steps_reg, steps_next;
    logic [mcg_pkg::OVF_W-1:0]  fidx_reg, fidx_next;
    logic [mcg_pkg::SCAN_W-1:0] scan_reg, scan_next;
    logic [mcg_pkg::SLOT_W-1:0] loc_reg, loc_next;
    logic have_reg, have_next, link_reg, link_next;
    logic [mcg_pkg::OVERFLOW_ENTRIES-1:0] free_map_reg, free_map_next;
    mcg_pkg::result_t res_reg, res_next;

    // shared slot compare
    mcg_pkg::slot_t             slot_cur, slot_want;
    logic                       scan_end, slot_hit, have_now, id_zero, id_match;
    logic [mcg_pkg::SLOT_W-1:0] loc_now, last_idx;
    logic [mcg_pkg::STEP_W-1:0] steps_inc;
    mcg_pkg::slot_row_t         row_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mcg_pkg::S_CLEAR;
            clr_reg      <= '0;
            free_map_reg <= '1;
            scan_reg     <= '0;
            steps_reg    <= '0;
            link_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            free_map_reg <= free_map_next;
            scan_reg     <= scan_next;
            steps_reg    <= steps_next;
            link_reg     <= link_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        member_reg <= member_next;
        cur_reg    <= cur_next;
        head_reg   <= head_next;
        target_reg <= target_next;
        tail_reg   <= tail_next;
        fidx_reg   <= fidx_next;
        loc_reg    <= loc_next;
        have_reg   <= have_next;
        res_reg    <= res_next;
    end

    always_comb begin
        slot_want = {1'b1, member_reg};
        slot_cur  = mem_rsp.row[scan_reg[mcg_pkg::SLOT_W-1:0]];
        scan_end  = (scan_reg == mcg_pkg::SCAN_W'(SLOTS));
        slot_hit  = !scan_end && (slot_cur == slot_want);
        have_now  = have_reg || slot_hit;
        loc_now   = slot_hit ? scan_reg[mcg_pkg::SLOT_W-1:0] : loc_reg;
        last_idx  = mcg_pkg::SLOT_W'(scan_reg - 1'b1);
        id_zero   = (mem_rsp.id_hi == '0) && (mem_rsp.id_lo == '0);
        id_match  = (mem_rsp.id_hi == hi_reg) && (mem_rsp.id_lo == lo_reg);
        steps_inc = steps_reg + 1'b1;

        row_new = mem_rsp.row;
        if (op_reg == mcg_pkg::OP_ATTACH) begin
            row_new[loc_reg] = {1'b1, member_reg};
        end else begin
            row_new[loc_reg]  = mem_rsp.row[last_idx];
            row_new[last_idx] = '0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        member_next   = member_reg;
        cur_next      = cur_reg;
        head_next     = head_reg;
        target_next   = target_reg;
        tail_next     = tail_reg;
        clr_next      = clr_reg;
        steps_next    = steps_reg;
        fidx_next     = fidx_reg;
        scan_next     = scan_reg;
        loc_next      = loc_reg;
        have_next     = have_reg;
        link_next     = link_reg;
        free_map_next = free_map_reg;
        res_next      = res_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;

        mem_req           = '0;
        mem_req.rd_addr   = cur_reg;
        mem_req.wr_addr   = target_reg;
        mem_req.id_hi     = hi_reg;
        mem_req.id_lo     = lo_reg;
        mem_req.row       = row_new;
        mem_req.link_addr = target_reg;

        unique case (state_reg)
            mcg_pkg::S_CLEAR: begin
                mem_req.wr_addr   = clr_reg;
                mem_req.link_addr = clr_reg;
                mem_req.id_hi     = '0;
                mem_req.id_lo     = '0;
                mem_req.row       = '0;
                mem_req.id_we     = 1'b1;
                mem_req.row_we    = 1'b1;
                mem_req.link_we   = 1'b1;
                clr_next          = clr_reg + 1'b1;
                if (clr_reg == ENT_W'(mcg_pkg::TOTAL_ENTRIES - 1)) begin
                    state_next = mcg_pkg::S_IDLE;
                end
            end
            mcg_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next     = in_op;
                    hi_next     = in_id_hi;
                    lo_next     = in_id_lo;
                    member_next = in_member;
                    // bucket range equals the head count, so no wrap needed
                    head_next   = ENT_W'(in_bucket);
                    cur_next    = ENT_W'(in_bucket);
                    steps_next  = '0;
                    state_next  = mcg_pkg::S_RD_ENT;
                end
            end
            mcg_pkg::S_RD_ENT: begin
                mem_req.rd_en = 1'b1;
                state_next    = mcg_pkg::S_CHK_ENT;
            end
            mcg_pkg::S_CHK_ENT: begin
                priority if ((id_zero && cur_reg == head_reg) || (!id_zero && id_match)) begin
                    target_next = cur_reg;
                    link_next   = 1'b0;
                    state_next  = mcg_pkg::S_RD_ROW;
                end else if (id_zero) begin
                    res_next   = '{mcg_pkg::ST_BAD_CHAIN, cur_reg};
                    state_next = mcg_pkg::S_FIN;
                end else if (mem_rsp.link == '0) begin
                    tail_next = cur_reg;
                    if (op_reg == mcg_pkg::OP_ATTACH) begin
                        fidx_next  = '0;
                        state_next = mcg_pkg::S_FREE_SCAN;
                    end else begin
                        res_next   = '{mcg_pkg::ST_NOT_FOUND, '0};
                        state_next = mcg_pkg::S_FIN;
                    end
                end else if (steps_inc >= mcg_pkg::STEP_W'(mcg_pkg::TOTAL_ENTRIES)) begin
                    // link width covers the table exactly; only the step limit trips
                    res_next   = '{mcg_pkg::ST_BAD_CHAIN, cur_reg};
                    state_next = mcg_pkg::S_FIN;
                end else begin
                    steps_next = steps_inc;
                    cur_next   = mem_rsp.link;
                    state_next = mcg_pkg::S_RD_ENT;
                end
            end
            mcg_pkg::S_FREE_SCAN: begin
                priority if (free_map_reg[fidx_reg]) begin
                    target_next = ENT_W'(mcg_pkg::HASH_BUCKETS) + ENT_W'(fidx_reg);
                    link_next   = 1'b1;
                    state_next  = mcg_pkg::S_RD_ROW;
                end else if (fidx_reg == mcg_pkg::OVF_W'(mcg_pkg::OVERFLOW_ENTRIES - 1)) begin
                    res_next   = '{mcg_pkg::ST_NO_OVERFLOW, '0};
                    state_next = mcg_pkg::S_FIN;
                end else begin
                    fidx_next = fidx_reg + 1'b1;
                end
            end
            mcg_pkg::S_RD_ROW: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = target_reg;
                scan_next       = '0;
                have_next       = 1'b0;
                state_next      = mcg_pkg::S_SCAN;
            end
            mcg_pkg::S_SCAN: begin
                if (op_reg == mcg_pkg::OP_ATTACH) begin
                    priority if (scan_end) begin
                        res_next   = '{mcg_pkg::ST_FULL, target_reg};
                        state_next = mcg_pkg::S_FIN;
                    end else if (!slot_cur[mcg_pkg::MEMBER_W]) begin
                        loc_next   = scan_reg[mcg_pkg::SLOT_W-1:0];
                        state_next = mcg_pkg::S_COMMIT;
                    end else begin
                        scan_next = scan_reg + 1'b1;
                    end
                end else begin
                    have_next = have_now;
                    loc_next  = loc_now;
                    if (scan_end || !slot_cur[mcg_pkg::MEMBER_W]) begin
                        if (have_now) begin
                            state_next = mcg_pkg::S_COMMIT;
                        end else begin
                            res_next   = '{mcg_pkg::ST_NO_MEMBER, target_reg};
                            state_next = mcg_pkg::S_FIN;
                        end
                    end else begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end
            mcg_pkg::S_COMMIT: begin
                mem_req.row_we = 1'b1;
                res_next       = '{mcg_pkg::ST_OK, target_reg};
                if (op_reg == mcg_pkg::OP_ATTACH) begin
                    mem_req.id_we     = 1'b1;
                    mem_req.link_we   = link_reg;
                    mem_req.link_data = '0;
                end
                if (op_reg == mcg_pkg::OP_ATTACH && link_reg) begin
                    free_map_next[fidx_reg] = 1'b0;
                    state_next              = mcg_pkg::S_LINK;
                end else begin
                    state_next = mcg_pkg::S_FIN;
                end
            end
            mcg_pkg::S_LINK: begin
                mem_req.link_we   = 1'b1;
                mem_req.link_addr = tail_reg;
                mem_req.link_data = target_reg;
                state_next        = mcg_pkg::S_FIN;
            end
            mcg_pkg::S_FIN: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = mcg_pkg::S_IDLE;
                end
            end
            default: state_next = mcg_pkg::S_IDLE;
        endcase
    end

    assign res = res_reg;

    `MCG_ASSERT_NEXT(a_free_map_mono, 1'b1, $countones(free_map_reg) <= $past($countones(free_map_reg)), "overflow entry returned to free map")
    `MCG_ASSERT_IMPL(a_scan_bound, 1'b1, scan_reg <= mcg_pkg::SCAN_W'(SLOTS), "slot scan ran past row")
    `MCG_ASSERT_IMPL(a_link_attach, state_reg == mcg_pkg::S_LINK, link_reg && op_reg == mcg_pkg::OP_ATTACH, "tail link written without new overflow entry")

endmodule
